// ===== rtl/plc_pkg.sv =====
// Shared types, constants and status codes for the paired Luhn code checker.
package plc_pkg;

    // Default required code length in characters
    localparam int CODE_LENGTH_DEF = 20;

    // Position counter width and saturation value
    localparam int POS_W = 7;
    localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

    // Character, digit and status widths
    localparam int CHAR_W = 8;
    localparam int DIGIT_W = 4;
    localparam int STATUS_W = 3;

    // Packed result width on the output stream, rounded up to whole bytes
    localparam int RES_W = STATUS_W + 2 * DIGIT_W;
    localparam int RES_TDATA_W = ((RES_W + 7) / 8) * 8;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [DIGIT_W:0] MOD_BASE = 5'd10;
    localparam logic [DIGIT_W:0] DOUBLE_FOLD = 5'd9;

    // Check status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_LENGTH = 3'd1,
        ST_REPEAT = 3'd2,
        ST_DIGIT  = 3'd3,
        ST_SUM    = 3'd4
    } status_t;

    // Decoded character: digit flag and weighted digit value
    typedef struct packed {
        logic                 is_digit;
        logic [DIGIT_W-1:0]   value;
    } digit_t;

    // One result item
    typedef struct packed {
        status_t              status;
        logic [DIGIT_W-1:0]   odd_sum;
        logic [DIGIT_W-1:0]   even_sum;
    } result_t;

    // Add a digit to an accumulator, modulo 10
    function automatic logic [DIGIT_W-1:0] add_mod10(input logic [DIGIT_W-1:0] acc,
                                                     input logic [DIGIT_W-1:0] v);
        logic [DIGIT_W:0] s;
        s = {1'b0, acc} + {1'b0, v};
        if (s >= MOD_BASE)
        begin
            s = s - MOD_BASE;
        end
        return s[DIGIT_W-1:0];
    endfunction

endpackage

// ===== rtl/plc_char_decode.sv =====
// Character decoder: digit check and Luhn doubling of one input byte.
module plc_char_decode (
    input  logic [plc_pkg::CHAR_W-1:0] char_code,
    input  logic                       double_en,
    output plc_pkg::digit_t            digit
);
    import plc_pkg::*;

    logic [CHAR_W-1:0]  offset;
    logic [DIGIT_W:0]   doubled;
    logic [DIGIT_W:0]   folded;

    // Strip the ASCII offset and double when the pair asks for it
    always_comb
    begin
        offset = char_code - CHAR_ZERO;
        doubled = {offset[DIGIT_W-1:0], 1'b0};
        folded = (doubled > DOUBLE_FOLD) ? (doubled - DOUBLE_FOLD) : doubled;
        digit.is_digit = (char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE);
        if (!digit.is_digit)
        begin
            digit.value = '0;
        end
        else if (double_en)
        begin
            digit.value = folded[DIGIT_W-1:0];
        end
        else
        begin
            digit.value = offset[DIGIT_W-1:0];
        end
    end

endmodule

// ===== rtl/plc_out_reg.sv =====
// Result register holding one check result until the master side takes it.
module plc_out_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            load,
    input  plc_pkg::result_t                load_data,
    output logic                            free,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: check_status[2:0], even_pos_sum[6:3],
    // odd_pos_sum[10:7], zero fill
    output logic [plc_pkg::RES_TDATA_W-1:0] m_tdata
);
    import plc_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // Slot is free when empty or being drained this cycle
    assign free = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag across stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on load
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata = {{(RES_TDATA_W - RES_W){1'b0}},
                      data_reg.odd_sum, data_reg.even_sum, data_reg.status};

endmodule

// ===== rtl/paired_luhn_code_checker.sv =====
// Top level of the paired Luhn code checker: input stage, code state, result.
//
// Usage: a code arrives on the slave stream one ASCII character per transfer
// (s_tdata), with s_tlast high on its final character. Characters at even and
// odd positions feed two mod-10 sums; every other pair, starting with the
// first, is doubled Luhn style. On the final character one result transfer
// leaves on the master stream: status (bad length, repeated character,
// non-digit, sum fail in that precedence, else accepted) and both sums.
// Timing: a character is registered in the input stage at its transfer and
// processed as it leaves that stage; the final character's result is then
// registered in the result register. One character per cycle is sustained
// while the result register is free to take each final character.
// Reset clears the valid flags of the input stage and the result register, and all code state.
// When the master side stalls, the pending result holds in the result
// register; ordinary characters keep flowing and a further final character
// waits in the input stage until the result is taken.
module paired_luhn_code_checker #(
    parameter int CODE_LENGTH = plc_pkg::CODE_LENGTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata fields from bit 0 up: char_code[7:0]
    input  logic [plc_pkg::CHAR_W-1:0]      s_tdata,
    // s_tlast: last_char
    input  logic                            s_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata fields from bit 0 up: check_status[2:0], even_pos_sum[6:3],
    // odd_pos_sum[10:7], zero fill
    output logic [plc_pkg::RES_TDATA_W-1:0] m_tdata
);
    import plc_pkg::*;

    localparam logic [POS_W:0] LEN_C = (POS_W + 1)'(CODE_LENGTH);
    localparam logic [POS_W:0] REP_END = (POS_W + 1)'(CODE_LENGTH - 1);

    // Input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // Code state
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [DIGIT_W-1:0] even_reg;
    logic [DIGIT_W-1:0] even_next;
    logic [DIGIT_W-1:0] odd_reg;
    logic [DIGIT_W-1:0] odd_next;
    logic [CHAR_W-1:0]  first_reg;
    logic [CHAR_W-1:0]  first_next;
    logic               same_reg;
    logic               same_next;
    logic               bad_reg;
    logic               bad_next;

    logic    out_free;
    logic    advance;
    logic    s_xfer;
    digit_t  digit;
    result_t result;

    // Advance the input stage; a final character needs a free result slot
    assign advance = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_xfer)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            in_char_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    plc_char_decode u_decode (
        .char_code (in_char_reg),
        .double_en (!pos_reg[1]),
        .digit     (digit)
    );

    // Update sums and flags, then decide the status on the final character
    always_comb
    begin
        even_next = even_reg;
        odd_next = odd_reg;
        first_next = first_reg;
        same_next = same_reg;
        bad_next = bad_reg || !digit.is_digit;
        if (!pos_reg[0])
        begin
            even_next = add_mod10(even_reg, digit.value);
        end
        else
        begin
            odd_next = add_mod10(odd_reg, digit.value);
        end
        if (pos_reg == '0)
        begin
            first_next = in_char_reg;
        end
        else if (({1'b0, pos_reg} < REP_END) && (in_char_reg != first_reg))
        begin
            same_next = 1'b0;
        end
        pos_next = (pos_reg < POS_MAX) ? (pos_reg + 1'b1) : pos_reg;

        result.even_sum = even_next;
        result.odd_sum = odd_next;
        priority if (({1'b0, pos_reg} + 1'b1) != LEN_C)
        begin
            result.status = ST_LENGTH;
        end
        else if (same_next)
        begin
            result.status = ST_REPEAT;
        end
        else if (bad_next)
        begin
            result.status = ST_DIGIT;
        end
        else if ((even_next != '0) || (odd_next != '0))
        begin
            result.status = ST_SUM;
        end
        else
        begin
            result.status = ST_OK;
        end
    end

    // Hold code state; return to reset values after the final character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            even_reg <= '0;
            odd_reg <= '0;
            first_reg <= '0;
            same_reg <= 1'b1;
            bad_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                pos_reg <= '0;
                even_reg <= '0;
                odd_reg <= '0;
                first_reg <= '0;
                same_reg <= 1'b1;
                bad_reg <= 1'b0;
            end
            else
            begin
                pos_reg <= pos_next;
                even_reg <= even_next;
                odd_reg <= odd_next;
                first_reg <= first_next;
                same_reg <= same_next;
                bad_reg <= bad_next;
            end
        end
    end

    plc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && in_last_reg),
        .load_data (result),
        .free      (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== bench/tb_top.sv =====
// Self-checking bench for the paired Luhn code checker: directed codes, then random codes.
module tb_top;
    import plc_pkg::*;

    localparam int CODE_LEN   = CODE_LENGTH_DEF;
    localparam int RAND_CHARS = 1250;
    localparam int SLACK_CYC  = 8;

    // Expected outcome of one code
    typedef struct packed {
        status_t            st;
        logic [DIGIT_W-1:0] ev;
        logic [DIGIT_W-1:0] od;
    } verdict_t;

    // One row of the directed table; typed rows carry a hand-written verdict
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        verdict_t          v;
    } dir_row_t;

    typedef enum int {
        GEN_VALID, GEN_SUMFAIL, GEN_REPEAT, GEN_NONDIGIT,
        GEN_SHORT, GEN_LONG, GEN_OVERLONG, GEN_NOISE
    } gen_mode_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [CHAR_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RES_TDATA_W-1:0] m_tdata;

    // Checker state kept alongside the block
    logic [POS_W-1:0]       code_pos;
    logic [DIGIT_W-1:0]     even_run;
    logic [DIGIT_W-1:0]     odd_run;
    logic [CHAR_W-1:0]      lead_char;
    bit                     lead_repeat;
    bit                     saw_non_digit;

    verdict_t               verdict_q[$];
    dir_row_t               dir_tab[$];
    bit                     quiet = 1'b0;
    int                     n_fail = 0;
    int                     n_chars = 0;
    int                     n_codes = 0;
    int                     n_checked = 0;
    int                     status_cnt[5] = '{0, 0, 0, 0, 0};

    paired_luhn_code_checker #(
        .CODE_LENGTH(CODE_LEN)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock: period 10
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Watchdog
    initial
    begin
        #5000000;
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [DIGIT_W-1:0] sum_mod10(input logic [DIGIT_W-1:0] a,
                                                     input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= 5'd10)
        begin
            s = s - 5'd10;
        end
        return s[DIGIT_W-1:0];
    endfunction

    // Weight of a digit at a position: double in pairs 0, 2, 4, ... and fold above 9
    function automatic logic [DIGIT_W-1:0] luhn_weight(input int pos, input int d);
        int w;
        w = d;
        if (((pos >> 1) & 1) == 0)
        begin
            w = 2 * d;
            if (w > 9)
            begin
                w = w - 9;
            end
        end
        return w[DIGIT_W-1:0];
    endfunction

    function automatic dir_row_t mk_row(input logic [CHAR_W-1:0] ch, input logic last,
                                        input logic typed, input status_t st,
                                        input logic [DIGIT_W-1:0] ev,
                                        input logic [DIGIT_W-1:0] od);
        dir_row_t r;
        r.ch = ch;
        r.last = last;
        r.typed = typed;
        r.v.st = st;
        r.v.ev = ev;
        r.v.od = od;
        return r;
    endfunction

    task automatic luhn_clear();
        code_pos = '0;
        even_run = '0;
        odd_run = '0;
        lead_char = '0;
        lead_repeat = 1'b1;
        saw_non_digit = 1'b0;
    endtask

    // Fold one character into the checker state; at the last one, produce the verdict
    task automatic luhn_absorb(input logic [CHAR_W-1:0] ch, input logic last,
                               output bit done, output verdict_t v);
        logic [DIGIT_W-1:0] w;
        bit                 is_digit;
        int                 len_now;
        is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
        w = '0;
        if (is_digit)
        begin
            w = luhn_weight(int'(code_pos), int'(ch - CHAR_ZERO));
        end
        else
        begin
            saw_non_digit = 1'b1;
        end
        if (!code_pos[0])
        begin
            even_run = sum_mod10(even_run, w);
        end
        else
        begin
            odd_run = sum_mod10(odd_run, w);
        end
        if (code_pos == '0)
        begin
            lead_char = ch;
        end
        else if (int'(code_pos) < CODE_LEN - 1 && ch != lead_char)
        begin
            lead_repeat = 1'b0;
        end
        len_now = int'(code_pos) + 1;
        if (code_pos != POS_MAX)
        begin
            code_pos = code_pos + 1'b1;
        end
        done = last;
        v.st = ST_OK;
        v.ev = even_run;
        v.od = odd_run;
        if (last)
        begin
            if (len_now != CODE_LEN)
                v.st = ST_LENGTH;
            else if (lead_repeat)
                v.st = ST_REPEAT;
            else if (saw_non_digit)
                v.st = ST_DIGIT;
            else if (even_run != '0 || odd_run != '0)
                v.st = ST_SUM;
            luhn_clear();
        end
    endtask

    // Present one character, hold it until the transfer, then record its verdict
    task automatic drive_char(input logic [CHAR_W-1:0] ch, input logic last,
                              input logic typed, input verdict_t typed_v);
        bit       done;
        verdict_t v;
        while (!quiet && $urandom_range(0, 99) < 8)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        n_chars++;
        luhn_absorb(ch, last, done, v);
        if (done)
        begin
            n_codes++;
            verdict_q.push_back(typed ? typed_v : v);
        end
    endtask

    // Build one random code of the given kind and send it
    task automatic send_code(input gen_mode_t mode);
        logic [CHAR_W-1:0]  code_q[$];
        logic [DIGIT_W-1:0] part;
        logic [CHAR_W-1:0]  rep_ch;
        verdict_t           none;
        int                 len;
        int                 k;
        int                 d;
        int                 hits;
        none = '0;
        case (mode)
            GEN_VALID, GEN_NONDIGIT:
            begin
                for (k = 0; k < CODE_LEN - 2; k++)
                begin
                    code_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
                end
                // Close each sum with the last even and last odd digit
                for (k = CODE_LEN - 2; k < CODE_LEN; k++)
                begin
                    part = '0;
                    for (int j = k % 2; j < k; j += 2)
                    begin
                        part = sum_mod10(part, luhn_weight(j, int'(code_q[j] - CHAR_ZERO)));
                    end
                    for (d = 0; d < 10; d++)
                    begin
                        if (sum_mod10(part, luhn_weight(k, d)) == '0)
                            break;
                    end
                    code_q.push_back(CHAR_W'(CHAR_ZERO + d));
                end
                if (mode == GEN_NONDIGIT)
                begin
                    hits = $urandom_range(1, 3);
                    repeat (hits)
                    begin
                        k = $urandom_range(0, CODE_LEN - 1);
                        code_q[k] = CHAR_W'($urandom_range(0, 1) ? $urandom_range(0, 47)
                                                                 : $urandom_range(58, 255));
                    end
                end
            end
            GEN_REPEAT:
            begin
                rep_ch = ($urandom_range(0, 9) < 7) ? CHAR_W'(CHAR_ZERO + $urandom_range(0, 9))
                                                   : CHAR_W'($urandom_range(0, 255));
                for (k = 0; k < CODE_LEN - 1; k++)
                begin
                    code_q.push_back(rep_ch);
                end
                code_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
                // Break the run on its final covered character now and then
                if ($urandom_range(0, 2) == 0)
                begin
                    code_q[CODE_LEN - 2] = rep_ch ^ 8'h01;
                end
            end
            GEN_NOISE:
            begin
                len = $urandom_range(0, 1) ? CODE_LEN : $urandom_range(1, CODE_LEN + 2);
                for (k = 0; k < len; k++)
                begin
                    code_q.push_back(CHAR_W'($urandom_range(0, 255)));
                end
            end
            default:
            begin
                case (mode)
                    GEN_SHORT:    len = $urandom_range(1, CODE_LEN - 1);
                    GEN_LONG:     len = $urandom_range(CODE_LEN + 1, CODE_LEN + 10);
                    GEN_OVERLONG: len = $urandom_range(126, 135);
                    default:      len = CODE_LEN;
                endcase
                for (k = 0; k < len; k++)
                begin
                    code_q.push_back(CHAR_W'(CHAR_ZERO + $urandom_range(0, 9)));
                end
            end
        endcase
        foreach (code_q[i])
        begin
            drive_char(code_q[i], i == code_q.size() - 1, 1'b0, none);
        end
    endtask

    // Result side: stall at random except during the quiet stretch
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= quiet || ($urandom_range(0, 99) >= 8);
    end

    // Compare each result transfer with the oldest pending verdict
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (verdict_q.size() == 0)
            begin
                $error("result transfer with no code pending: tdata=%h", m_tdata);
                n_fail++;
            end
            else
            begin
                want = verdict_q.pop_front();
                n_checked++;
                status_cnt[int'(want.st)]++;
                if (m_tdata[2:0] !== want.st)
                begin
                    $error("check_status: expected %0d, got %0d", want.st, m_tdata[2:0]);
                    n_fail++;
                end
                if (m_tdata[6:3] !== want.ev)
                begin
                    $error("even_pos_sum: expected %0d, got %0d", want.ev, m_tdata[6:3]);
                    n_fail++;
                end
                if (m_tdata[10:7] !== want.od)
                begin
                    $error("odd_pos_sum: expected %0d, got %0d", want.od, m_tdata[10:7]);
                    n_fail++;
                end
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int r;
        int waited;
        rst_n = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tlast <= 1'b0;
        luhn_clear();

        // Single characters: length wins over everything, including a zero byte
        dir_tab.push_back(mk_row(8'h30, 1'b1, 1'b1, ST_LENGTH, 4'd0, 4'd0));
        dir_tab.push_back(mk_row(8'hFF, 1'b1, 1'b1, ST_LENGTH, 4'd0, 4'd0));
        dir_tab.push_back(mk_row(8'h00, 1'b1, 1'b1, ST_LENGTH, 4'd0, 4'd0));
        // Accepted code: 5 5 9 9 then zeros; both sums close to zero
        dir_tab.push_back(mk_row(8'h35, 1'b0, 1'b0, ST_OK, 4'd0, 4'd0));
        dir_tab.push_back(mk_row(8'h35, 1'b0, 1'b0, ST_OK, 4'd0, 4'd0));
        dir_tab.push_back(mk_row(8'h39, 1'b0, 1'b0, ST_OK, 4'd0, 4'd0));
        dir_tab.push_back(mk_row(8'h39, 1'b0, 1'b0, ST_OK, 4'd0, 4'd0));
        for (int i = 4; i < CODE_LEN - 1; i++)
        begin
            dir_tab.push_back(mk_row(8'h30, 1'b0, 1'b0, ST_OK, 4'd0, 4'd0));
        end
        dir_tab.push_back(mk_row(8'h30, 1'b1, 1'b1, ST_OK, 4'd0, 4'd0));
        // Two-character code, checked against the predictor
        dir_tab.push_back(mk_row(8'h39, 1'b0, 1'b0, ST_OK, 4'd0, 4'd0));
        dir_tab.push_back(mk_row(8'h31, 1'b1, 1'b0, ST_OK, 4'd0, 4'd0));

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
        begin
            drive_char(dir_tab[i].ch, dir_tab[i].last, dir_tab[i].typed, dir_tab[i].v);
        end

        // Random codes, mostly well formed, with a stretch free of idling
        while (n_chars < dir_tab.size() + RAND_CHARS)
        begin
            quiet = (n_chars >= 500) && (n_chars < 800);
            r = $urandom_range(0, 99);
            if (r < 35)
                send_code(GEN_VALID);
            else if (r < 50)
                send_code(GEN_SUMFAIL);
            else if (r < 60)
                send_code(GEN_REPEAT);
            else if (r < 72)
                send_code(GEN_NONDIGIT);
            else if (r < 80)
                send_code(GEN_SHORT);
            else if (r < 88)
                send_code(GEN_LONG);
            else if (r < 90)
                send_code(GEN_OVERLONG);
            else
                send_code(GEN_NOISE);
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;
        s_tlast <= 1'b0;

        // Drain pending results, then let the pipeline settle
        waited = 0;
        while (verdict_q.size() != 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SLACK_CYC) @(posedge clk);
        if (verdict_q.size() != 0)
        begin
            $error("%0d results never arrived", verdict_q.size());
            n_fail++;
        end

        $display("Sent %0d characters in %0d codes; checked %0d results.",
                 n_chars, n_codes, n_checked);
        $display("Outcomes: ok %0d, length %0d, repeat %0d, non-digit %0d, sum %0d.",
                 status_cnt[0], status_cnt[1], status_cnt[2], status_cnt[3], status_cnt[4]);
        if (n_fail == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule
